### hdl/ngpc_pkg.sv
// Shared types, constants and lookup helpers for the name group packing codec.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package ngpc_pkg;

    localparam int GROUP_SIZE = 3;
    localparam int BASE = 38;
    localparam int GROUP_LIMIT = BASE * BASE * BASE;
    localparam int NRANGES = 107;
    localparam logic [15:0] MARK = 16'h0021;

    localparam logic [1:0] REG_DIRECTION = 2'd0;
    localparam logic [1:0] REG_MAX_PLAIN = 2'd1;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_ALPHABET = 2'd1,
        ERR_UNMAPPED = 2'd2,
        ERR_GROUP    = 2'd3
    } err_t;

    typedef struct packed {
        logic [15:0] sym;
        logic        last;
        err_t        err;
    } result_t;

    // The last three entries are empty placeholders: each one covers the single
    // code unit zero and takes one packed value.
    localparam logic [15:0] RANGE_LO [NRANGES] = '{
        16'h00A0, 16'h0100, 16'h0180, 16'h0250, 16'h02B0,
        16'h0300, 16'h0370, 16'h0400, 16'h0500, 16'h0530,
        16'h0590, 16'h0600, 16'h0700, 16'h0780, 16'h0900,
        16'h0980, 16'h0A00, 16'h0A80, 16'h0B00, 16'h0B80,
        16'h0C00, 16'h0C80, 16'h0D00, 16'h0D80, 16'h0E00,
        16'h0E80, 16'h0F00, 16'h1000, 16'h10A0, 16'h1100,
        16'h1200, 16'h13A0, 16'h1400, 16'h1680, 16'h16A0,
        16'h1700, 16'h1720, 16'h1740, 16'h1760, 16'h1780,
        16'h1800, 16'h1900, 16'h1950, 16'h19E0, 16'h1D00,
        16'h1E00, 16'h1F00, 16'h2000, 16'h2070, 16'h20A0,
        16'h20D0, 16'h2100, 16'h2150, 16'h2190, 16'h2200,
        16'h2300, 16'h2400, 16'h2440, 16'h2460, 16'h2500,
        16'h2580, 16'h25A0, 16'h2600, 16'h2700, 16'h27C0,
        16'h27F0, 16'h2800, 16'h2900, 16'h2980, 16'h2A00,
        16'h2B00, 16'h2E80, 16'h2F00, 16'h2FF0, 16'h3000,
        16'h3040, 16'h30A0, 16'h3100, 16'h3130, 16'h3190,
        16'h31A0, 16'h31F0, 16'h3200, 16'h3300, 16'h3400,
        16'h4DC0, 16'h4E00, 16'hA000, 16'hA490, 16'hAC00,
        16'hD800, 16'hDB80, 16'hDC00, 16'hE000, 16'hF900,
        16'hFB00, 16'hFB50, 16'hFE00, 16'hFE20, 16'hFE30,
        16'hFE50, 16'hFE70, 16'hFF00, 16'hFFF0,
        16'h0000, 16'h0000, 16'h0000
    };

    localparam logic [15:0] RANGE_HI [NRANGES] = '{
        16'h00FF, 16'h017F, 16'h024F, 16'h02AF, 16'h02FF,
        16'h036F, 16'h03FF, 16'h04FF, 16'h052F, 16'h058F,
        16'h05FF, 16'h06FF, 16'h074F, 16'h07BF, 16'h097F,
        16'h09FF, 16'h0A7F, 16'h0AFF, 16'h0B7F, 16'h0BFF,
        16'h0C7F, 16'h0CFF, 16'h0D7F, 16'h0DFF, 16'h0E7F,
        16'h0EFF, 16'h0FFF, 16'h109F, 16'h10FF, 16'h11FF,
        16'h137F, 16'h13FF, 16'h167F, 16'h169F, 16'h16FF,
        16'h171F, 16'h173F, 16'h175F, 16'h177F, 16'h17FF,
        16'h18AF, 16'h194F, 16'h197F, 16'h19FF, 16'h1D7F,
        16'h1EFF, 16'h1FFF, 16'h206F, 16'h209F, 16'h20CF,
        16'h20FF, 16'h214F, 16'h218F, 16'h21FF, 16'h22FF,
        16'h23FF, 16'h243F, 16'h245F, 16'h24FF, 16'h257F,
        16'h259F, 16'h25FF, 16'h26FF, 16'h27BF, 16'h27EF,
        16'h27FF, 16'h28FF, 16'h297F, 16'h29FF, 16'h2AFF,
        16'h2BFF, 16'h2EFF, 16'h2FDF, 16'h2FFF, 16'h303F,
        16'h309F, 16'h30FF, 16'h312F, 16'h318F, 16'h319F,
        16'h31BF, 16'h31FF, 16'h32FF, 16'h33FF, 16'h4DBF,
        16'h4DFF, 16'h9FFF, 16'hA48F, 16'hA4CF, 16'hD7AF,
        16'hDB7F, 16'hDBFF, 16'hDFFF, 16'hF8FF, 16'hFAFF,
        16'hFB4F, 16'hFDFF, 16'hFE0F, 16'hFE2F, 16'hFE4F,
        16'hFE6F, 16'hFEFF, 16'hFFEF, 16'hFFFF,
        16'h0000, 16'h0000, 16'h0000
    };

    // Size of one range.
    function automatic logic [16:0] range_size(input int i);
        return 17'(RANGE_HI[i]) - 17'(RANGE_LO[i]) + 17'd1;
    endfunction

    // First packed value of range i; values count from one.
    function automatic logic [16:0] range_base(input int i);
        logic [16:0] acc;
        acc = 17'd1;
        for (int j = 0; j < i; j++) begin
            acc = acc + range_size(j);
        end
        return acc;
    endfunction

    function automatic logic [5:0] digit_of(input logic [15:0] c);
        logic [5:0] d;
        d = 6'd0;
        if (c >= 16'h0041 && c <= 16'h005A) begin
            d = 6'(c - 16'h0041) + 6'd1;
        end else if (c >= 16'h0030 && c <= 16'h0039) begin
            d = 6'(c - 16'h0030) + 6'd27;
        end else if (c == 16'h005F) begin
            d = 6'd37;
        end
        return d;
    endfunction

    function automatic logic [15:0] char_of(input logic [5:0] d);
        logic [15:0] c;
        c = 16'd0;
        if (d >= 6'd1 && d <= 6'd26) begin
            c = 16'h0041 + 16'(d) - 16'd1;
        end else if (d >= 6'd27 && d <= 6'd36) begin
            c = 16'h0030 + 16'(d) - 16'd27;
        end else if (d == 6'd37) begin
            c = 16'h005F;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/ngpc_range_map.sv
// Parallel range compare between code units and packed group values.
// Depends on ngpc_pkg for the range table.
`default_nettype none
module ngpc_range_map (
    input  wire logic [15:0] unit_in,
    input  wire logic [15:0] value_in,
    output logic      [16:0] value_out,
    output logic      [15:0] unit_out
);

    logic [16:0] base_v;
    logic [16:0] val_x;
    logic        hit;

    always_comb begin
        value_out = 17'd0;
        unit_out  = 16'd0;
        hit       = 1'b0;
        val_x     = 17'(value_in);
        for (int i = 0; i < ngpc_pkg::NRANGES; i++) begin
            base_v = ngpc_pkg::range_base(i);
            // Take the first matching range; the empty placeholders overlap.
            if (!hit && unit_in >= ngpc_pkg::RANGE_LO[i]
                     && unit_in <= ngpc_pkg::RANGE_HI[i]) begin
                value_out = base_v + 17'(unit_in - ngpc_pkg::RANGE_LO[i]);
                hit       = 1'b1;
            end
            if (val_x >= base_v && val_x < base_v + ngpc_pkg::range_size(i)) begin
                unit_out = unit_out | (ngpc_pkg::RANGE_LO[i] + 16'(val_x - base_v));
            end
        end
    end

endmodule
`default_nettype wire

### hdl/ngpc_digit_split.sv
// Splits a group value below 38^3 into three base-38 digits by reciprocal multiply.
// Depends on ngpc_pkg for the base.
`default_nettype none
module ngpc_digit_split (
    input  wire logic [15:0] value_in,
    output logic      [5:0]  dig2,
    output logic      [5:0]  dig1,
    output logic      [5:0]  dig0,
    output logic      [1:0]  dig_count
);

    // floor(v/38) = (v*K1)>>26, floor(v/1444) = (v*K2)>>32, exact for v < 38^3
    localparam logic [36:0] K1 = 37'd1766023;
    localparam logic [37:0] K2 = 38'd2974355;

    logic [36:0] p1;
    logic [37:0] p2;
    logic [10:0] q1;
    logic [5:0]  q2;
    logic [15:0] r0;
    logic [10:0] r1;

    always_comb begin
        p1 = 37'(value_in) * K1;
        p2 = 38'(value_in) * K2;
        q1 = p1[36:26];
        q2 = p2[37:32];
        r0 = value_in - 16'(q1) * 16'(ngpc_pkg::BASE);
        r1 = q1 - 11'(q2) * 11'(ngpc_pkg::BASE);
        dig0 = r0[5:0];
        dig1 = r1[5:0];
        dig2 = q2;
        if (q2 != 6'd0) begin
            dig_count = 2'd3;
        end else if (q1 != 11'd0) begin
            dig_count = 2'd2;
        end else begin
            dig_count = 2'd1;
        end
    end

endmodule
`default_nettype wire

### hdl/ngpc_out_buf.sv
// Result register: holds up to three results of one item and hands them out in order.
// Depends on ngpc_pkg for the result type.
`default_nettype none
module ngpc_out_buf (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load,
    input  wire ngpc_pkg::result_t [2:0]      load_res,
    input  wire logic [1:0]                   load_count,
    input  wire logic                         m_ready,
    output logic                              m_valid,
    output ngpc_pkg::result_t                 head,
    output logic                              free
);

    ngpc_pkg::result_t [2:0] slot_reg;
    logic [1:0] count_reg, count_next;
    logic [1:0] idx_reg, idx_next;
    logic       drain_done;

    always_comb begin
        m_valid    = count_reg != 2'd0;
        head       = slot_reg[idx_reg];
        drain_done = m_valid && m_ready && (idx_reg == count_reg - 2'd1);
        free       = (count_reg == 2'd0) || drain_done;
        count_next = count_reg;
        idx_next   = idx_reg;
        if (load) begin
            count_next = load_count;
            idx_next   = 2'd0;
        end else if (drain_done) begin
            count_next = 2'd0;
            idx_next   = 2'd0;
        end else if (m_valid && m_ready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end else begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= load_res;
        end
    end

endmodule
`default_nettype wire

### hdl/name_group_packing_codec.sv
// Top level of the name group packing codec: framing state, step logic, result register.
// Depends on ngpc_pkg, ngpc_range_map, ngpc_digit_split and ngpc_out_buf.
//
// Usage:
//   The s_ channel carries one 16-bit character per item with s_last_in on the final
//   character of a name and s_name_length (sampled at each name's first item).
//   The m_ channel returns characters or code units with m_last_out and m_error_code.
//   The cfg channel writes direction (index 0) and max_plain_length (index 1); it is
//   always ready. Writing direction restarts name framing. Write only while idle.
//   Results of an accepted item are registered and appear in the cycle after it is taken.
//   Throughput: an item causing zero or one result is taken every cycle while m_ready is
//   high; an item that causes two or three results (marker plus unit, or a decoded
//   triple) holds the input until the single result port drains the result register.
//   A new item is taken in the same cycle the last pending result leaves.
//   Stall: while m_ready is low results hold and s_ready stays low once results wait.
//   Reset (aresetn low, synchronous): encode, limit 32, framing at name start,
//   result register empty.
`default_nettype none
module name_group_packing_codec (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_symbol_in,
    input  wire logic        s_last_in,
    input  wire logic [9:0]  s_name_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [15:0] m_symbol_out,
    output logic             m_last_out,
    output logic      [1:0]  m_error_code,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

    // configuration
    logic       direction_reg, direction_next;
    logic [9:0] max_plain_reg, max_plain_next;

    // name framing and open group
    logic [15:0] group_value_reg, group_value_next;
    logic [1:0]  group_count_reg, group_count_next;
    logic        group_bad_reg, group_bad_next;
    logic        at_start_reg, at_start_next;
    logic        shortened_reg, shortened_next;

    logic        s_fire;
    logic        buf_free;
    ngpc_pkg::result_t [2:0] res;
    logic [1:0]  res_count;
    ngpc_pkg::result_t head;

    // step datapath
    logic [15:0] gv_base;
    logic [1:0]  cnt_base;
    logic        bad_base;
    logic [5:0]  enc_digit;
    logic [15:0] enc_value;
    logic [1:0]  enc_count;
    logic        enc_bad;
    logic        short_now;
    logic [16:0] map_value;
    logic [15:0] map_unit;
    logic [5:0]  dig [3];
    logic [1:0]  dig_count;

    assign cfg_ready = 1'b1;
    assign s_ready   = buf_free;
    assign s_fire    = s_valid && s_ready;

    // Open group restarts with each name.
    assign gv_base   = at_start_reg ? 16'd0 : group_value_reg;
    assign cnt_base  = at_start_reg ? 2'd0 : group_count_reg;
    assign bad_base  = at_start_reg ? 1'b0 : group_bad_reg;
    assign enc_digit = ngpc_pkg::digit_of(s_symbol_in);
    assign enc_value = 16'((gv_base << 5) + (gv_base << 2) + (gv_base << 1)) + 16'(enc_digit);
    assign enc_count = cnt_base + 2'd1;
    assign enc_bad   = bad_base || (enc_digit == 6'd0);

    ngpc_range_map u_map (
        .unit_in   (s_symbol_in),
        .value_in  (enc_value),
        .value_out (map_value),
        .unit_out  (map_unit)
    );

    ngpc_digit_split u_split (
        .value_in  (map_value[15:0]),
        .dig2      (dig[2]),
        .dig1      (dig[1]),
        .dig0      (dig[0]),
        .dig_count (dig_count)
    );

    always_comb begin
        res              = '0;
        res_count        = 2'd0;
        short_now        = 1'b0;
        group_value_next = group_value_reg;
        group_count_next = group_count_reg;
        group_bad_next   = group_bad_reg;
        at_start_next    = at_start_reg;
        shortened_next   = shortened_reg;
        if (!direction_reg) begin
            short_now = at_start_reg ? (s_name_length > max_plain_reg) : shortened_reg;
            shortened_next = short_now;
            // Emit the marker ahead of a shortened name.
            if (at_start_reg && short_now) begin
                res[0]    = '{sym: ngpc_pkg::MARK, last: 1'b0, err: ngpc_pkg::ERR_OK};
                res_count = 2'd1;
            end
            if (!short_now) begin
                res[res_count] = '{sym: s_symbol_in, last: s_last_in,
                                   err: ngpc_pkg::ERR_OK};
                res_count      = res_count + 2'd1;
            end else if (enc_count >= 2'(ngpc_pkg::GROUP_SIZE) || s_last_in) begin
                res[res_count].sym  = map_unit;
                res[res_count].last = s_last_in;
                if (enc_bad) begin
                    res[res_count].err = ngpc_pkg::ERR_ALPHABET;
                end else if (enc_value == 16'd0) begin
                    res[res_count].err = ngpc_pkg::ERR_GROUP;
                end else begin
                    res[res_count].err = ngpc_pkg::ERR_OK;
                end
                res_count        = res_count + 2'd1;
                group_value_next = 16'd0;
                group_count_next = 2'd0;
                group_bad_next   = 1'b0;
            end else begin
                group_value_next = enc_value;
                group_count_next = enc_count;
                group_bad_next   = enc_bad;
            end
            at_start_next = s_last_in;
        end else begin
            if (at_start_reg && s_symbol_in == ngpc_pkg::MARK) begin
                // Marker opens a shortened name; alone it is an empty group.
                shortened_next = 1'b1;
                at_start_next  = s_last_in;
                if (s_last_in) begin
                    res[0]    = '{sym: 16'd0, last: 1'b1, err: ngpc_pkg::ERR_GROUP};
                    res_count = 2'd1;
                end
            end else begin
                short_now      = at_start_reg ? 1'b0 : shortened_reg;
                shortened_next = short_now;
                at_start_next  = s_last_in;
                if (!short_now) begin
                    res[0]    = '{sym: s_symbol_in, last: s_last_in, err: ngpc_pkg::ERR_OK};
                    res_count = 2'd1;
                end else if (map_value == 17'd0) begin
                    res[0]    = '{sym: 16'd0, last: s_last_in, err: ngpc_pkg::ERR_UNMAPPED};
                    res_count = 2'd1;
                end else if (map_value >= 17'(ngpc_pkg::GROUP_LIMIT)) begin
                    res[0]    = '{sym: 16'd0, last: s_last_in, err: ngpc_pkg::ERR_GROUP};
                    res_count = 2'd1;
                end else begin
                    // Most significant digit first; an inner zero digit is flagged.
                    for (int k = 2; k >= 0; k--) begin
                        if (2'(k) < dig_count) begin
                            res[res_count].sym  = ngpc_pkg::char_of(dig[k]);
                            res[res_count].last = s_last_in && (k == 0);
                            res[res_count].err  = (dig[k] == 6'd0) ? ngpc_pkg::ERR_GROUP
                                                                   : ngpc_pkg::ERR_OK;
                            res_count           = res_count + 2'd1;
                        end
                    end
                end
            end
        end
    end

    ngpc_out_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (s_fire),
        .load_res   (res),
        .load_count (res_count),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .head       (head),
        .free       (buf_free)
    );

    assign m_symbol_out = head.sym;
    assign m_last_out   = head.last;
    assign m_error_code = head.err;

    always_comb begin
        direction_next = direction_reg;
        max_plain_next = max_plain_reg;
        if (cfg_valid && cfg_index == ngpc_pkg::REG_DIRECTION) begin
            direction_next = cfg_data[0];
        end
        if (cfg_valid && cfg_index == ngpc_pkg::REG_MAX_PLAIN) begin
            max_plain_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg   <= 1'b0;
            max_plain_reg   <= 10'd32;
            group_value_reg <= 16'd0;
            group_count_reg <= 2'd0;
            group_bad_reg   <= 1'b0;
            at_start_reg    <= 1'b1;
            shortened_reg   <= 1'b0;
        end else begin
            direction_reg <= direction_next;
            max_plain_reg <= max_plain_next;
            if (cfg_valid && cfg_index == ngpc_pkg::REG_DIRECTION) begin
                // Restart framing and drop the open group.
                group_value_reg <= 16'd0;
                group_count_reg <= 2'd0;
                group_bad_reg   <= 1'b0;
                at_start_reg    <= 1'b1;
                shortened_reg   <= 1'b0;
            end else if (s_fire) begin
                group_value_reg <= group_value_next;
                group_count_reg <= group_count_next;
                group_bad_reg   <= group_bad_next;
                at_start_reg    <= at_start_next;
                shortened_reg   <= shortened_next;
            end
        end
    end

    // Input is taken only when no result would be left waiting.
    a_ready_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && m_valid) |-> m_ready)
        else $error("input taken while results still pending");

    // A long name in encode starts with the marker.
    a_marker_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !direction_reg && at_start_reg && s_name_length > max_plain_reg)
        |=> (m_valid && m_symbol_out == ngpc_pkg::MARK))
        else $error("shortened name does not open with marker");

    // The open group never holds a full group between items.
    a_group_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        group_count_reg < 2'(ngpc_pkg::GROUP_SIZE))
        else $error("open group overflow");

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for name_group_packing_codec: directed table, then random names.
// Depends on ngpc_pkg (result type, error codes, register indexes, range table) and the RTL.
`default_nettype none
module tb;

    localparam logic [1:0] REG_UNUSED = 2'd3;   // no register behind this index
    localparam int UNIT_VALUES = 38 * 38 * 38;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] sym;
        logic        lst;
        logic [9:0]  len;      // name length, or write data for a register row
        logic [1:0]  idx;
        bit          typed;    // expected result written in the row
        ngpc_pkg::result_t res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_symbol_in;
    logic        s_last_in;
    logic [9:0]  s_name_length;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_symbol_out;
    logic        m_last_out;
    logic [1:0]  m_error_code;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;

    name_group_packing_codec u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_symbol_in   (s_symbol_in),
        .s_last_in     (s_last_in),
        .s_name_length (s_name_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol_out  (m_symbol_out),
        .m_last_out    (m_last_out),
        .m_error_code  (m_error_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Shadow state of the codec.
    logic        decode_dir;
    logic [9:0]  plain_limit;
    logic [15:0] grp_val;
    logic [1:0]  grp_cnt;
    logic        grp_bad;
    logic        name_start;
    logic        packed_name;

    ngpc_pkg::result_t expected_results[$];
    int      fail_count = 0;
    int      items_sent = 0;
    bit      quiet = 0;       // no idling on either side
    bit      long_hold = 0;   // receiver holds off for a long stretch

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Limit on the whole run.
    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [5:0] alpha_digit(input logic [15:0] c);
        if (c >= 16'h0041 && c <= 16'h005A) return 6'(c - 16'h0041 + 1);
        if (c >= 16'h0030 && c <= 16'h0039) return 6'(c - 16'h0030 + 27);
        if (c == 16'h005F) return 6'd37;
        return 6'd0;
    endfunction

    function automatic logic [15:0] digit_char(input int d);
        if (d >= 1 && d <= 26) return 16'(16'h0041 + d - 1);
        if (d >= 27 && d <= 36) return 16'(16'h0030 + d - 27);
        if (d == 37) return 16'h005F;
        return 16'h0000;
    endfunction

    // Packed value (counting from one through the range table) to code unit.
    function automatic logic [15:0] unit_of_value(input int v);
        int base;
        int span;
        base = 1;
        for (int i = 0; i < ngpc_pkg::NRANGES; i++) begin
            span = int'(ngpc_pkg::RANGE_HI[i]) - int'(ngpc_pkg::RANGE_LO[i]) + 1;
            if (v >= base && v < base + span)
                return 16'(int'(ngpc_pkg::RANGE_LO[i]) + v - base);
            base += span;
        end
        return 16'h0000;
    endfunction

    function automatic int value_of_unit(input logic [15:0] u);
        int base;
        base = 1;
        for (int i = 0; i < ngpc_pkg::NRANGES; i++) begin
            if (u >= ngpc_pkg::RANGE_LO[i] && u <= ngpc_pkg::RANGE_HI[i])
                return base + int'(u - ngpc_pkg::RANGE_LO[i]);
            base += int'(ngpc_pkg::RANGE_HI[i]) - int'(ngpc_pkg::RANGE_LO[i]) + 1;
        end
        return 0;
    endfunction

    function automatic void queue_result(input logic [15:0] sym, input logic lst,
                                         input ngpc_pkg::err_t e);
        ngpc_pkg::result_t r;
        r.sym  = sym;
        r.last = lst;
        r.err  = e;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void clear_group();
        grp_val = '0;
        grp_cnt = '0;
        grp_bad = 1'b0;
    endfunction

    function automatic void pack_char(input logic [15:0] sym, input logic lst,
                                      input logic [9:0] len);
        logic [5:0]     d;
        ngpc_pkg::err_t e;
        if (name_start) begin
            packed_name = len > plain_limit;
            name_start  = 1'b0;
            clear_group();
            if (packed_name) queue_result(ngpc_pkg::MARK, 1'b0, ngpc_pkg::ERR_OK);
        end
        if (!packed_name) begin
            queue_result(sym, lst, ngpc_pkg::ERR_OK);
        end else begin
            d = alpha_digit(sym);
            if (d == 0) grp_bad = 1'b1;
            grp_val = 16'(grp_val * 38 + d);
            grp_cnt = grp_cnt + 2'd1;
            if (grp_cnt >= ngpc_pkg::GROUP_SIZE || lst) begin
                e = grp_bad ? ngpc_pkg::ERR_ALPHABET
                            : (grp_val == 0 ? ngpc_pkg::ERR_GROUP : ngpc_pkg::ERR_OK);
                queue_result(unit_of_value(grp_val), lst, e);
                clear_group();
            end
        end
        if (lst) name_start = 1'b1;
    endfunction

    function automatic void unpack_unit(input logic [15:0] sym, input logic lst);
        int v;
        int digs[3];
        int cnt;
        if (name_start) begin
            name_start  = 1'b0;
            packed_name = sym == ngpc_pkg::MARK;
            if (packed_name) begin
                // a marker with nothing after it
                if (lst) begin
                    queue_result(16'h0000, 1'b1, ngpc_pkg::ERR_GROUP);
                    name_start = 1'b1;
                end
                return;
            end
        end
        if (!packed_name) begin
            queue_result(sym, lst, ngpc_pkg::ERR_OK);
        end else begin
            v = value_of_unit(sym);
            if (v == 0) begin
                queue_result(16'h0000, lst, ngpc_pkg::ERR_UNMAPPED);
            end else if (v >= UNIT_VALUES) begin
                queue_result(16'h0000, lst, ngpc_pkg::ERR_GROUP);
            end else begin
                cnt = 0;
                while (v != 0 && cnt < 3) begin
                    digs[cnt] = v % 38;
                    v = v / 38;
                    cnt++;
                end
                // most significant digit first; an inner zero digit is flagged
                for (int i = cnt - 1; i >= 0; i--) begin
                    queue_result(digit_char(digs[i]), lst && i == 0,
                                 digs[i] == 0 ? ngpc_pkg::ERR_GROUP : ngpc_pkg::ERR_OK);
                end
            end
        end
        if (lst) name_start = 1'b1;
    endfunction

    // ---------------------------------------------------------------- drivers
    // All driver tasks are entered and left at a falling edge.

    task automatic offer_item(input logic [15:0] sym, input logic lst, input logic [9:0] len);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_symbol_in   = sym;
        s_last_in     = lst;
        s_name_length = len;
        do @(posedge aclk); while (!s_ready);
        if (decode_dir) unpack_unit(sym, lst);
        else pack_char(sym, lst, len);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        s_valid   = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == ngpc_pkg::REG_DIRECTION) begin
            decode_dir  = val[0];
            name_start  = 1'b1;
            packed_name = 1'b0;
            clear_group();
        end else if (idx == ngpc_pkg::REG_MAX_PLAIN) begin
            plain_limit = val;
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Hold the sender until every expected result has come, plus the block's latency.
    task automatic drain();
        s_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic random_name();
        int          n;
        logic [9:0]  len;
        logic [15:0] sym;
        n = $urandom_range(1, 10);
        if (!decode_dir) begin
            len = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(1, 1023)) : 10'(n);
            for (int i = 0; i < n; i++) begin
                sym = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                  : digit_char($urandom_range(1, 37));
                offer_item(sym, i == n - 1, len);
            end
        end else begin
            len = 10'($urandom_range(1, 1023));
            if ($urandom_range(0, 4) != 0) begin
                n = $urandom_range(0, 6);
                offer_item(ngpc_pkg::MARK, n == 0, len);
                for (int i = 0; i < n; i++) begin
                    sym = ($urandom_range(0, 6) == 0)
                        ? 16'($urandom) : unit_of_value($urandom_range(1, UNIT_VALUES - 1));
                    offer_item(sym, i == n - 1, len);
                end
            end else begin
                for (int i = 0; i < n; i++) offer_item(16'($urandom), i == n - 1, len);
            end
        end
    endtask

    // ---------------------------------------------------------------- receiver

    initial begin
        int burst;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                // long enough for the result register to fill and stall the input
                m_ready = 1'b0;
                repeat (60) @(negedge aclk);
                long_hold = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                burst = $urandom_range(1, 12);
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        ngpc_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: symbol_out %h", m_symbol_out);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_symbol_out !== want.sym) begin
                    $error("symbol_out: expected %h, got %h", want.sym, m_symbol_out);
                    fail_count++;
                end
                if (m_last_out !== want.last) begin
                    $error("last_out: expected %b, got %b", want.last, m_last_out);
                    fail_count++;
                end
                if (m_error_code !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, m_error_code);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    stim_row_t directed[$];

    function automatic stim_row_t item_row(input logic [15:0] sym, input logic lst,
                                           input logic [9:0] len);
        stim_row_t r;
        r.kind  = ROW_ITEM;
        r.sym   = sym;
        r.lst   = lst;
        r.len   = len;
        r.idx   = '0;
        r.typed = 0;
        r.res   = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [15:0] sym, input logic lst,
                                            input logic [9:0] len, input logic [15:0] rsym,
                                            input ngpc_pkg::err_t e);
        stim_row_t r;
        r          = item_row(sym, lst, len);
        r.typed    = 1;
        r.res.sym  = rsym;
        r.res.last = lst;
        r.res.err  = e;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [9:0] val);
        stim_row_t r;
        r      = item_row('0, 1'b0, val);
        r.kind = ROW_CFG;
        r.idx  = idx;
        return r;
    endfunction

    function automatic void add_row(input stim_row_t r);
        directed.insert(directed.size(), r);
    endfunction

    initial begin
        int phase;
        int phase_start;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_symbol_in   = '0;
        s_last_in     = 1'b0;
        s_name_length = 10'd1;
        cfg_valid     = 1'b0;
        cfg_index     = ngpc_pkg::REG_DIRECTION;
        cfg_data      = '0;
        decode_dir    = 1'b0;
        plain_limit   = 10'd32;
        name_start    = 1'b1;
        packed_name   = 1'b0;
        clear_group();

        // Encode with the shortest limit: plain extremes, then packed groups.
        add_row(cfg_row(ngpc_pkg::REG_DIRECTION, 10'd0));
        add_row(cfg_row(ngpc_pkg::REG_MAX_PLAIN, 10'd1));
        add_row(typed_row(16'hFFFF, 1'b1, 10'd1, 16'hFFFF, ngpc_pkg::ERR_OK));
        add_row(typed_row(16'h0000, 1'b1, 10'd1, 16'h0000, ngpc_pkg::ERR_OK));
        add_row(item_row(16'h0041, 1'b0, 10'd3));
        add_row(item_row(16'h005A, 1'b0, 10'd3));
        add_row(item_row(16'h005F, 1'b1, 10'd3));
        add_row(item_row(16'h0061, 1'b0, 10'd2));   // lower case is bad
        add_row(item_row(16'h0039, 1'b1, 10'd2));
        add_row(item_row(16'h0000, 1'b1, 10'd1023)); // bad char, group value zero
        add_row(cfg_row(ngpc_pkg::REG_MAX_PLAIN, 10'd1023));
        add_row(typed_row(16'h0051, 1'b1, 10'd1023, 16'h0051, ngpc_pkg::ERR_OK));
        add_row(cfg_row(REG_UNUSED, 10'd1));
        // Decode: lone marker, unmapped, overlong, inner zero digit, plain.
        add_row(cfg_row(ngpc_pkg::REG_DIRECTION, 10'd1));
        add_row(typed_row(ngpc_pkg::MARK, 1'b1, 10'd1, 16'h0000, ngpc_pkg::ERR_GROUP));
        add_row(item_row(ngpc_pkg::MARK, 1'b0, 10'd2));
        add_row(typed_row(16'h0750, 1'b1, 10'd2, 16'h0000, ngpc_pkg::ERR_UNMAPPED));
        add_row(item_row(ngpc_pkg::MARK, 1'b0, 10'd4));
        add_row(item_row(16'hFFFF, 1'b0, 10'd4));
        add_row(item_row(16'h00C5, 1'b0, 10'd4));
        add_row(typed_row(16'h00A1, 1'b1, 10'd4, 16'h0042, ngpc_pkg::ERR_OK));
        add_row(typed_row(16'h0041, 1'b1, 10'd1, 16'h0041, ngpc_pkg::ERR_OK));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                drain();
                write_reg(directed[i].idx, directed[i].len);
            end else begin
                offer_item(directed[i].sym, directed[i].lst, directed[i].len);
                if (directed[i].typed) expected_results[$] = directed[i].res;
            end
        end

        // Random phases: alternate direction, sweep the limit, whole names only.
        phase = 0;
        while (items_sent < 260) begin
            drain();
            write_reg(ngpc_pkg::REG_DIRECTION, 10'(phase % 2));
            case (phase)
                0:       write_reg(ngpc_pkg::REG_MAX_PLAIN, 10'd1);
                1:       write_reg(ngpc_pkg::REG_MAX_PLAIN, 10'd1023);
                default: write_reg(ngpc_pkg::REG_MAX_PLAIN, 10'($urandom_range(1, 8)));
            endcase
            if (phase == 2) long_hold = 1;
            if (items_sent > 215) quiet = 1;
            phase_start = items_sent;
            while (items_sent - phase_start < 35) begin
                random_name();
                // in phase 3, pause the sender mid-phase until the output is empty
                if (phase == 3 && items_sent - phase_start > 15 && items_sent - phase_start < 22)
                    drain();
            end
            phase++;
        end

        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
hdl/ngpc_pkg.sv
hdl/ngpc_range_map.sv
hdl/ngpc_digit_split.sv
hdl/ngpc_out_buf.sv
hdl/name_group_packing_codec.sv
tb/tb.sv
